// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/podc_pkg.sv =====
`timescale 1ns / 1ps

package podc_pkg;

  localparam int YEAR_BITS  = 14;
  localparam int DAY_W      = 5;
  localparam int MONTH_W    = 4;
  localparam int OVERLAP_W  = 22;
  localparam int CUM_W      = 9;
  // 365*y plus the leap terms stays below 512*(y+1)
  localparam int SERIAL_W   = YEAR_BITS + 9;
  localparam int ACC_W      = SERIAL_W + 1;
  localparam int CENTURY    = 100;
  localparam int REM_W      = 7;
  localparam int DAYS_PER_YEAR = 365;
  localparam logic [OVERLAP_W-1:0] OVERLAP_MAX = {OVERLAP_W{1'b1}};

  typedef struct packed {
    logic [DAY_W-1:0]     first_start_day;
    logic [MONTH_W-1:0]   first_start_month;
    logic [YEAR_BITS-1:0] first_start_year;
    logic [DAY_W-1:0]     first_end_day;
    logic [MONTH_W-1:0]   first_end_month;
    logic [YEAR_BITS-1:0] first_end_year;
    logic [DAY_W-1:0]     second_start_day;
    logic [MONTH_W-1:0]   second_start_month;
    logic [YEAR_BITS-1:0] second_start_year;
    logic [DAY_W-1:0]     second_end_day;
    logic [MONTH_W-1:0]   second_end_month;
    logic [YEAR_BITS-1:0] second_end_year;
  } podc_in_t;

  typedef struct packed {
    logic [OVERLAP_W-1:0] overlap_days;
    logic                 bad_date;
  } podc_out_t;

  // Control of the shared accumulator: clr starts from zero, sub negates the operand.
  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } acc_ctl_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                                  d = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4, 4'd6, 4'd9, 4'd11:               d = DAY_W'(30);
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = DAY_W'(31);
      default:                               d = '0;
    endcase
    return d;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                input logic leap);
    logic [CUM_W-1:0] c;
    case (m)
      4'd1:    c = CUM_W'(0);
      4'd2:    c = CUM_W'(31);
      4'd3:    c = CUM_W'(59);
      4'd4:    c = CUM_W'(90);
      4'd5:    c = CUM_W'(120);
      4'd6:    c = CUM_W'(151);
      4'd7:    c = CUM_W'(181);
      4'd8:    c = CUM_W'(212);
      4'd9:    c = CUM_W'(243);
      4'd10:   c = CUM_W'(273);
      4'd11:   c = CUM_W'(304);
      4'd12:   c = CUM_W'(334);
      default: c = '0;
    endcase
    if (leap && (m inside {[4'd3:4'd12]})) begin
      c = c + CUM_W'(1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/period_overlap_day_counter_core.sv =====
`timescale 1ns / 1ps
// Each of the four dates takes a divider launch, a divider wait, 6 accumulator terms
// and a store; then select, subtract and finish close the job.
// A new beat is taken only from idle; busy stays high for the whole job.
// Results show for one cycle on done; the receiver cannot stall.
// Reset (rst, synchronous, active high) returns to idle and drops done.
`include "assert_macros.svh"

module period_overlap_day_counter_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  podc_pkg::podc_in_t  dates,
  output logic                done,
  output podc_pkg::podc_out_t result
);
  import podc_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DIV_GO   = 14'b00000000000010,
    S_DIV_WAIT = 14'b00000000000100,
    S_T365     = 14'b00000000001000,
    S_T4       = 14'b00000000010000,
    S_T100     = 14'b00000000100000,
    S_T400     = 14'b00000001000000,
    S_TMON     = 14'b00000010000000,
    S_TDAY     = 14'b00000100000000,
    S_STORE    = 14'b00001000000000,
    S_SEL      = 14'b00010000000000,
    S_DIFF_LD  = 14'b00100000000000,
    S_DIFF_SUB = 14'b01000000000000,
    S_FINISH   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  // Held job beat and per-date working values.
  podc_in_t              item;
  logic [1:0]            k;
  logic                  bad;
  logic [SERIAL_W-1:0]   serial [4];
  logic [SERIAL_W-1:0]   lo;
  logic [SERIAL_W-1:0]   hi;

  logic [DAY_W-1:0]      day_cur;
  logic [MONTH_W-1:0]    mon_cur;
  logic [YEAR_BITS-1:0]  yr_cur;

  logic                  div_go;
  logic                  div_done;
  logic [YEAR_BITS-1:0]  quo;
  logic [REM_W-1:0]      rem;

  acc_ctl_t              ctl;
  logic [ACC_W-1:0]      opnd;
  logic [ACC_W-1:0]      acc;

  logic                  leap;
  logic                  date_ok;
  logic [YEAR_BITS-1:0]  c100;
  logic [YEAR_BITS-1:0]  c400;
  logic [SERIAL_W-1:0]   diff;
  logic [OVERLAP_W-1:0]  count;

  assign busy = (state != S_IDLE);

  // Pick the date under work: first start, first end, second start, second end.
  always_comb begin
    case (k)
      2'd0: begin
        day_cur = item.first_start_day;
        mon_cur = item.first_start_month;
        yr_cur  = item.first_start_year;
      end
      2'd1: begin
        day_cur = item.first_end_day;
        mon_cur = item.first_end_month;
        yr_cur  = item.first_end_year;
      end
      2'd2: begin
        day_cur = item.second_start_day;
        mon_cur = item.second_start_month;
        yr_cur  = item.second_start_year;
      end
      default: begin
        day_cur = item.second_end_day;
        mon_cur = item.second_end_month;
        yr_cur  = item.second_end_year;
      end
    endcase
  end

  // Leap rule from the divider: y%4==0 and y%100!=0, or y%400==0 (quotient%4==0).
  assign leap    = ((yr_cur[1:0] == 2'b00) && (rem != '0)) ||
                   ((rem == '0) && (quo[1:0] == 2'b00));
  assign date_ok = (day_cur != '0) && (day_cur <= month_days(mon_cur, leap));

  // Ceilings of y/100 and y/400 (the latter as ceil of the former over four).
  assign c100 = quo + YEAR_BITS'(rem != '0);
  assign c400 = (c100 >> 2) + YEAR_BITS'(c100[1:0] != 2'b00);

  podc_div100 #(
    .W (YEAR_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (yr_cur),
    .done (div_done),
    .quo  (quo),
    .rem  (rem)
  );

  podc_acc #(
    .W (ACC_W)
  ) u_acc (
    .clk  (clk),
    .ctl  (ctl),
    .opnd (opnd),
    .acc  (acc)
  );

  // Sequence the divider and the shared accumulator: one serial-number term per cycle.
  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    ctl        = '0;
    opnd       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        div_go     = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          state_next = S_T365;
        end
      end
      S_T365: begin
        ctl        = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        opnd       = ACC_W'(yr_cur) * ACC_W'(DAYS_PER_YEAR);
        state_next = S_T4;
      end
      S_T4: begin
        ctl        = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        opnd       = ACC_W'(yr_cur >> 2) + ACC_W'(yr_cur[1:0] != 2'b00);
        state_next = S_T100;
      end
      S_T100: begin
        ctl        = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        opnd       = ACC_W'(c100);
        state_next = S_T400;
      end
      S_T400: begin
        ctl        = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        opnd       = ACC_W'(c400);
        state_next = S_TMON;
      end
      S_TMON: begin
        ctl        = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        opnd       = ACC_W'(cum_days(mon_cur, leap));
        state_next = S_TDAY;
      end
      S_TDAY: begin
        ctl        = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        opnd       = ACC_W'(day_cur - DAY_W'(1));
        state_next = S_STORE;
      end
      S_STORE: begin
        state_next = (k == 2'd3) ? S_SEL : S_DIV_GO;
      end
      S_SEL: begin
        state_next = S_DIFF_LD;
      end
      S_DIFF_LD: begin
        ctl        = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        opnd       = ACC_W'(hi);
        state_next = S_DIFF_SUB;
      end
      S_DIFF_SUB: begin
        ctl        = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        opnd       = ACC_W'(lo);
        state_next = S_FINISH;
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Inclusive count from hi - lo; zero when the span is empty or a date is bad, clamp at the top.
  assign diff  = acc[SERIAL_W-1:0];
  always_comb begin
    if (bad || acc[ACC_W-1]) begin
      count = '0;
    end else if (diff >= SERIAL_W'(OVERLAP_MAX)) begin
      count = OVERLAP_MAX;
    end else begin
      count = OVERLAP_W'(diff + SERIAL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);
    end
  end

  // Datapath registers: hold the beat, advance the date index, keep serials, pick lo/hi, load the result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      item <= dates;
      k    <= 2'd0;
      bad  <= 1'b0;
    end
    if (state == S_STORE) begin
      serial[k] <= acc[SERIAL_W-1:0];
      bad       <= bad | ~date_ok;
      k         <= k + 2'd1;
    end
    if (state == S_SEL) begin
      lo <= (serial[0] > serial[2]) ? serial[0] : serial[2];
      hi <= (serial[1] < serial[3]) ? serial[1] : serial[3];
    end
    if (state == S_FINISH) begin
      result.overlap_days <= count;
      result.bad_date     <= bad;
    end
  end

  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `ASSERT_SAME(a_bad_zero, clk, rst, done && result.bad_date, result.overlap_days == '0)

endmodule

// ===== rtl/core/podc_div100.sv =====
`timescale 1ns / 1ps

module podc_div100 #(
  parameter int W = podc_pkg::YEAR_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [W-1:0]               num,
  output logic                       done,
  output logic [W-1:0]               quo,
  output logic [podc_pkg::REM_W-1:0] rem
);
  import podc_pkg::*;

  // Reciprocal of the century, scaled by 2**RECIP_SHIFT and rounded up.
  // The quotient is exact for every year below 91180.
  localparam int RECIP_SHIFT = 23;
  localparam int REC_W       = RECIP_SHIFT - 6;
  localparam int PROD_W      = W + REC_W;
  localparam int RECIP       = (2 ** RECIP_SHIFT + CENTURY - 1) / CENTURY;

  logic [W-1:0]      num_q;
  logic              mul_step;
  logic              rem_step;
  logic [PROD_W-1:0] prod;
  logic [W-1:0]      quo_x100;

  // Quotient by reciprocal multiply, remainder by multiply-back and subtract.
  assign prod     = PROD_W'(num_q) * PROD_W'(RECIP);
  assign quo_x100 = quo * W'(CENTURY);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_step <= 1'b0;
      rem_step <= 1'b0;
      done     <= 1'b0;
    end else begin
      mul_step <= go;
      rem_step <= mul_step;
      done     <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      num_q <= num;
    end
    if (mul_step) begin
      quo <= W'(prod >> RECIP_SHIFT);
    end
    if (rem_step) begin
      rem <= REM_W'(num_q - quo_x100);
    end
  end

endmodule

// ===== rtl/core/podc_acc.sv =====
`timescale 1ns / 1ps

module podc_acc #(
  parameter int W = podc_pkg::ACC_W
) (
  input  logic               clk,
  input  podc_pkg::acc_ctl_t ctl,
  input  logic [W-1:0]       opnd,
  output logic [W-1:0]       acc
);
  import podc_pkg::*;

  logic [W-1:0] base;
  logic [W-1:0] acc_next;

  // Single adder; subtract by inverting the operand and carrying in one.
  assign base     = ctl.clr ? '0 : acc;
  assign acc_next = base + (opnd ^ {W{ctl.sub}}) + W'(ctl.sub);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= acc_next;
    end
  end

endmodule
